// ----- hw/rtl/esd_pkg.sv -----
`default_nettype none

package esd_pkg;

  // Field widths of the sensor interface.
  localparam int TS_W       = 32;
  localparam int FREQ_W     = 10;
  localparam int CODE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_RISE   = 2'd0;
  localparam logic [1:0] REQ_FALL   = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_ETH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TEMP = 2'd3;

  // Configuration reset values.
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST   = 10'd48;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST   = 10'd152;
  localparam logic [CODE_W-1:0] FAULT_ETH_RST  = 8'd50;
  localparam logic [CODE_W-1:0] FAULT_TEMP_RST = 8'd165;

  // One second in microseconds, the numerator of the frequency.
  localparam logic [19:0] FREQ_SCALE = 20'd1000000;
  // Twice the frequency numerator, used for half-up rounding of 1e6/period.
  localparam logic [20:0] ETH_NUM    = 21'd2000000;
  localparam logic [CODE_W-1:0] ETH_OFFSET = 8'd50;

  // Temperature in 1/2000 degC is 83*low_us - 162500.
  localparam logic [6:0]  TEMP_MUL    = 7'd83;
  localparam logic [19:0] TEMP_BIAS   = 20'd162500;
  localparam logic [10:0] TEMP_DIV    = 11'd2000;
  localparam logic [10:0] TEMP_HALF   = 11'd1000;
  localparam logic [CODE_W-1:0] TEMP_OFFSET = 8'd40;
  // Smallest low time whose code saturates at the top of the range.
  localparam logic [TS_W-1:0] TEMP_LOW_SAT = 32'd7151;

  // Updates from the request decoder to the edge tracker.
  typedef struct packed {
    logic rise;
    logic fall;
    logic report;
  } esd_track_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/esd_edge_track.sv -----
`default_nettype none

module esd_edge_track
  import esd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire esd_track_ctl_t  ctl,
  input  wire logic [TS_W-1:0] ts,
  output logic      [TS_W-1:0] period_us,
  output logic      [TS_W-1:0] low_us,
  output logic                 edge_seen
);

  logic [TS_W-1:0] last_rise;
  logic [TS_W-1:0] last_fall;
  logic            rise_seen;
  logic            fall_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_seen <= 1'b0;
      fall_seen <= 1'b0;
      period_us <= '0;
      low_us    <= '0;
      edge_seen <= 1'b0;
    end else begin
      if (ctl.rise) begin
        if (rise_seen) begin
          period_us <= ts - last_rise;
        end
        if (fall_seen) begin
          low_us <= ts - last_fall;
        end
        rise_seen <= 1'b1;
        edge_seen <= 1'b1;
      end
      if (ctl.fall) begin
        fall_seen <= 1'b1;
        edge_seen <= 1'b1;
      end
      if (ctl.report) begin
        edge_seen <= 1'b0;
      end
    end
  end

  // Edge times are only read once their seen flag is set.
  always_ff @(posedge clk) begin
    if (ctl.rise) begin
      last_rise <= ts;
    end
    if (ctl.fall) begin
      last_fall <= ts;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/esd_window_chk.sv -----
`default_nettype none

module esd_window_chk
  import esd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TS_W-1:0]   period_us,
  input  wire logic [FREQ_W-1:0] min_freq_hz,
  input  wire logic [FREQ_W-1:0] max_freq_hz,
  output logic                   busy,
  output logic                   fault
);

  localparam int ACC_W = TS_W + FREQ_W;
  localparam int CNT_W = $clog2(FREQ_W + 1);

  logic [ACC_W-1:0]  mcand;
  logic [ACC_W-1:0]  acc_min;
  logic [ACC_W-1:0]  acc_max;
  logic [FREQ_W-1:0] mn_sh;
  logic [FREQ_W-1:0] mx_sh;
  logic [CNT_W-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(FREQ_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift-and-add: one bit of each frequency limit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= ACC_W'(period_us);
      mn_sh   <= min_freq_hz;
      mx_sh   <= max_freq_hz;
      acc_min <= '0;
      acc_max <= '0;
    end else if (busy) begin
      if (mn_sh[0]) begin
        acc_min <= acc_min + mcand;
      end
      if (mx_sh[0]) begin
        acc_max <= acc_max + mcand;
      end
      mcand <= mcand << 1;
      mn_sh <= mn_sh >> 1;
      mx_sh <= mx_sh >> 1;
    end
  end

  assign fault = (ACC_W'(FREQ_SCALE) > acc_max) || (ACC_W'(FREQ_SCALE) < acc_min);

endmodule

`default_nettype wire

// ----- hw/rtl/esd_eth_div.sv -----
`default_nettype none

module esd_eth_div
  import esd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TS_W-1:0]   period_us,
  output logic                   busy,
  output logic [CODE_W-1:0]      ethanol
);

  // Quotient bits: anything at or above 2^(QB-1) saturates the output.
  localparam int QB    = 10;
  localparam int REM_W = TS_W + 1;
  localparam int DIV_W = TS_W + QB;
  localparam int CNT_W = $clog2(QB + 1);

  logic [REM_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [DIV_W-1:0] rem_ext;
  logic [QB-1:0]    q;
  logic [QB-1:0]    q_off;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QB);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rem_ext = DIV_W'(rem);

  // Restoring division of (2e6 + p) by 2p, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(ETH_NUM) + REM_W'(period_us);
      dsh <= {period_us, QB'(0)};
      q   <= '0;
    end else if (busy) begin
      if (rem_ext >= dsh) begin
        rem <= rem - dsh[REM_W-1:0];
        q   <= {q[QB-2:0], 1'b1};
      end else begin
        q   <= {q[QB-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign q_off = q - QB'(ETH_OFFSET);

  always_comb begin
    if (q[QB-1]) begin
      ethanol = '1;
    end else if (q < QB'(ETH_OFFSET)) begin
      ethanol = '0;
    end else if (q_off > QB'(8'hFF)) begin
      ethanol = '1;
    end else begin
      ethanol = q_off[CODE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/esd_temp_calc.sv -----
`default_nettype none

module esd_temp_calc
  import esd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TS_W-1:0]   low_us,
  output logic                   busy,
  output logic [CODE_W-1:0]      temp_code
);

  localparam int LW    = 13;
  localparam int MW    = 7;
  localparam int PW    = 20;
  localparam int QB    = 8;
  localparam int CNT_W = 4;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_MUL  = 4'b0010,
    T_PREP = 4'b0100,
    T_DIV  = 4'b1000
  } temp_phase_t;

  temp_phase_t      phase;
  logic [CNT_W-1:0] cnt;
  logic             sat_hi;
  logic             neg;
  logic [PW-1:0]    mcand;
  logic [MW-1:0]    msh;
  logic [PW-1:0]    acc;
  logic [PW-1:0]    rem;
  logic [PW-1:0]    dsh;
  logic [QB-1:0]    q;
  logic [QB:0]      q_sum;

  assign busy = (phase != T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= T_IDLE;
      cnt   <= '0;
    end else begin
      unique case (phase)
        T_IDLE: begin
          if (start) begin
            phase <= T_MUL;
            cnt   <= CNT_W'(MW);
          end
        end
        T_MUL: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            phase <= T_PREP;
          end
        end
        T_PREP: begin
          phase <= T_DIV;
          cnt   <= CNT_W'(QB);
        end
        T_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            phase <= T_IDLE;
          end
        end
        default: begin
          phase <= T_IDLE;
        end
      endcase
    end
  end

  // Multiply the low time by 83 bit by bit, remove the bias, then divide the
  // magnitude plus half a step by 2000 one quotient bit per cycle.
  always_ff @(posedge clk) begin
    unique case (phase)
      T_IDLE: begin
        if (start) begin
          sat_hi <= (low_us >= TEMP_LOW_SAT);
          mcand  <= PW'(low_us[LW-1:0]);
          msh    <= TEMP_MUL;
          acc    <= '0;
        end
      end
      T_MUL: begin
        if (msh[0]) begin
          acc <= acc + mcand;
        end
        mcand <= mcand << 1;
        msh   <= msh >> 1;
      end
      T_PREP: begin
        neg <= (acc < TEMP_BIAS);
        if (acc < TEMP_BIAS) begin
          rem <= (TEMP_BIAS - acc) + PW'(TEMP_HALF);
        end else begin
          rem <= (acc - TEMP_BIAS) + PW'(TEMP_HALF);
        end
        dsh <= PW'(TEMP_DIV) << (QB - 1);
        q   <= '0;
      end
      T_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          q   <= {q[QB-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign q_sum = {1'b0, q} + (QB+1)'(TEMP_OFFSET);

  always_comb begin
    if (sat_hi) begin
      temp_code = '1;
    end else if (neg) begin
      if (q > TEMP_OFFSET) begin
        temp_code = '0;
      end else begin
        temp_code = TEMP_OFFSET - q;
      end
    end else if (q_sum[QB]) begin
      temp_code = '1;
    end else begin
      temp_code = q_sum[CODE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ethanol_sensor_pwm_decoder.sv -----
// Edge beats are taken back to back while the block is idle. A report with no edge since the
// last one gives its fault result through the OUT state and the output register. A report
// with a measured period runs the serial units; the temperature unit is the slowest (7
// multiply, 1 bias, 8 divide steps), then the result is registered. The input waits until
// then, longer while the output is stalled. Synchronous active-high reset clears the edge
// history and output register and loads the defaults (48 Hz, 152 Hz, fault values 50, 165).
`default_nettype none

module ethanol_sensor_pwm_decoder
  import esd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            req_type,
  input  wire logic [TS_W-1:0]       timestamp_us,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CODE_W-1:0]          eth_content,
  output logic [CODE_W-1:0]          temp_code,
  output logic                       sensor_fault,

  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // The sequencer has three states. In IDLE the block takes beats; in CALC the
  // three serial units work on a report; in OUT the result waits for the
  // output register to be free.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FREQ_W-1:0] min_freq_hz;
  logic [FREQ_W-1:0] max_freq_hz;
  logic [CODE_W-1:0] fault_ethanol;
  logic [CODE_W-1:0] fault_temp_code;

  // Handshake and request decode.
  logic           in_accept;
  logic           is_report;
  logic           out_free;
  esd_track_ctl_t track_ctl;

  // Edge tracker state seen by the sequencer.
  logic [TS_W-1:0] period_us;
  logic [TS_W-1:0] low_us;
  logic            edge_seen;

  // Serial units.
  logic              unit_start;
  logic              win_busy;
  logic              win_fault;
  logic              eth_busy;
  logic [CODE_W-1:0] eth_val;
  logic              temp_busy;
  logic [CODE_W-1:0] temp_val;
  logic              units_busy;

  // Whether the pending result carries the fault values.
  logic res_fault;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign is_report = in_accept && (req_type == REQ_REPORT);

  assign track_ctl.rise   = in_accept && (req_type == REQ_RISE);
  assign track_ctl.fall   = in_accept && (req_type == REQ_FALL);
  assign track_ctl.report = is_report;

  // The units only run when a report finds a fresh edge and a nonzero period;
  // without a fresh edge the fault result needs no arithmetic, and with a zero
  // period the report gives no result at all.
  assign unit_start = is_report && edge_seen && (period_us != '0);
  assign units_busy = win_busy || eth_busy || temp_busy;

  // The output register is free when it is empty or its beat leaves now.
  assign out_free = !out_valid || out_ready;

  // Configuration writes land directly; the user must send them only while idle, unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq_hz     <= MIN_FREQ_RST;
      max_freq_hz     <= MAX_FREQ_RST;
      fault_ethanol   <= FAULT_ETH_RST;
      fault_temp_code <= FAULT_TEMP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_FREQ:   min_freq_hz     <= cfg_data[FREQ_W-1:0];
        CFG_MAX_FREQ:   max_freq_hz     <= cfg_data[FREQ_W-1:0];
        CFG_FAULT_ETH:  fault_ethanol   <= cfg_data[CODE_W-1:0];
        CFG_FAULT_TEMP: fault_temp_code <= cfg_data[CODE_W-1:0];
        default:        min_freq_hz     <= min_freq_hz;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (is_report) begin
            if (!edge_seen) begin
              state <= S_OUT;
            end else if (period_us != '0) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (!units_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A report without a fresh edge is a fault outright; otherwise the
  // frequency window decides once the units are done.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && is_report && !edge_seen) begin
      res_fault <= 1'b1;
    end else if (state == S_CALC && !units_busy) begin
      res_fault <= win_fault;
    end
  end

  // Output register: the result beat waits here, so the block can take the
  // next beat on the input side while it is pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      if (res_fault) begin
        eth_content  <= fault_ethanol;
        temp_code    <= fault_temp_code;
        sensor_fault <= 1'b1;
      end else begin
        eth_content  <= eth_val;
        temp_code    <= temp_val;
        sensor_fault <= 1'b0;
      end
    end
  end

  esd_edge_track u_edge_track (
    .clk       (clk),
    .rst       (rst),
    .ctl       (track_ctl),
    .ts        (timestamp_us),
    .period_us (period_us),
    .low_us    (low_us),
    .edge_seen (edge_seen)
  );

  // Frequency window: min*period and max*period against 1e6.
  esd_window_chk u_window_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (unit_start),
    .period_us   (period_us),
    .min_freq_hz (min_freq_hz),
    .max_freq_hz (max_freq_hz),
    .busy        (win_busy),
    .fault       (win_fault)
  );

  // Ethanol percent: round(1e6/period) - 50.
  esd_eth_div u_eth_div (
    .clk       (clk),
    .rst       (rst),
    .start     (unit_start),
    .period_us (period_us),
    .busy      (eth_busy),
    .ethanol   (eth_val)
  );

  // Temperature code from the low time; this is the slowest of the three units.
  esd_temp_calc u_temp_calc (
    .clk       (clk),
    .rst       (rst),
    .start     (unit_start),
    .low_us    (low_us),
    .busy      (temp_busy),
    .temp_code (temp_val)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/esd_checker.sv -----
`default_nettype none

module esd_checker
  import esd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [1:0]        req_type,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CODE_W-1:0] eth_content,
  input wire logic [CODE_W-1:0] temp_code,
  input wire logic              sensor_fault
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(eth_content) &&
      $stable(temp_code) && $stable(sensor_fault))
    else $error("result beat changed while stalled");

  // Edge beats and unused codes finish in the cycle they are taken.
  a_edge_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type != REQ_REPORT) |=> in_ready)
    else $error("non-report beat blocked the input");

  // A new result only appears after the sequencer left the idle state.
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a report in flight");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ethanol_sensor_pwm_decoder esd_checker u_esd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .eth_content  (eth_content),
  .temp_code    (temp_code),
  .sensor_fault (sensor_fault)
);

`default_nettype wire
